@@ rtl/usdc_pkg.sv @@
package usdc_pkg;

  // table size default
  localparam int unsigned USDC_TABLE_ENTRIES = 64;

  // field widths
  localparam int unsigned USDC_CMD_W  = 2;
  localparam int unsigned USDC_SLOT_W = 6;
  localparam int unsigned USDC_ADDR_W = 32;
  localparam int unsigned USDC_PORT_W = 16;
  localparam int unsigned USDC_ETYP_W = 16;
  localparam int unsigned USDC_PROT_W = 8;
  localparam int unsigned USDC_TIER_W = 2;
  localparam int unsigned USDC_VERD_W = 3;

  // protocol constants
  localparam logic [USDC_ETYP_W-1:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [USDC_ETYP_W-1:0] ETYPE_VLAN = 16'h8100;
  localparam logic [USDC_PROT_W-1:0] PROTO_UDP  = 8'd17;
  localparam logic [USDC_ADDR_W-1:0] ADDR_ANY   = 32'd0;
  localparam logic [3:0]             MCAST_NIB  = 4'hE;

  // command codes
  localparam logic [USDC_CMD_W-1:0] CMD_CLASSIFY = 2'd0;
  localparam logic [USDC_CMD_W-1:0] CMD_WRITE    = 2'd1;
  localparam logic [USDC_CMD_W-1:0] CMD_CLEAR    = 2'd2;

  // verdict codes
  localparam logic [USDC_VERD_W-1:0] V_TAKEN     = 3'd0;
  localparam logic [USDC_VERD_W-1:0] V_NOT_IPV4  = 3'd1;
  localparam logic [USDC_VERD_W-1:0] V_NOT_UDP   = 3'd2;
  localparam logic [USDC_VERD_W-1:0] V_MULTICAST = 3'd3;
  localparam logic [USDC_VERD_W-1:0] V_NO_MATCH  = 3'd4;
  localparam logic [USDC_VERD_W-1:0] V_TABLE     = 3'd5;

  // match tier codes
  localparam logic [USDC_TIER_W-1:0] TIER_NONE  = 2'd0;
  localparam logic [USDC_TIER_W-1:0] TIER_FULL  = 2'd1;
  localparam logic [USDC_TIER_W-1:0] TIER_LOCAL = 2'd2;
  localparam logic [USDC_TIER_W-1:0] TIER_PORT  = 2'd3;

  // first hit found so far in one tier
  typedef struct packed {
    logic                   hit;
    logic [USDC_SLOT_W-1:0] slot;
  } usdc_hit_t;

  // item moving down the cell chain
  typedef struct packed {
    logic [USDC_CMD_W-1:0]  cmd;
    logic [USDC_SLOT_W-1:0] slot;
    logic [USDC_ADDR_W-1:0] lcl_addr;
    logic [USDC_ADDR_W-1:0] rmt_addr;
    logic [USDC_PORT_W-1:0] lcl_port;
    logic [USDC_PORT_W-1:0] rmt_port;
    logic [USDC_VERD_W-1:0] verdict;
    usdc_hit_t              full;
    usdc_hit_t              local_only;
    usdc_hit_t              port_only;
  } usdc_token_t;

endpackage

@@ rtl/usdc_in_if.sv @@
interface usdc_in_if import usdc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [USDC_CMD_W-1:0]  cmd;
  logic [USDC_SLOT_W-1:0] slot;
  logic [USDC_ADDR_W-1:0] lcl_addr;
  logic [USDC_ADDR_W-1:0] rmt_addr;
  logic [USDC_PORT_W-1:0] lcl_port;
  logic [USDC_PORT_W-1:0] rmt_port;
  logic [USDC_ETYP_W-1:0] ether_type;
  logic [USDC_ETYP_W-1:0] vlan_inner_type;
  logic [USDC_PROT_W-1:0] ip_protocol;

  modport source (
    output valid, cmd, slot, lcl_addr, rmt_addr, lcl_port, rmt_port,
           ether_type, vlan_inner_type, ip_protocol,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, lcl_addr, rmt_addr, lcl_port, rmt_port,
           ether_type, vlan_inner_type, ip_protocol,
    output ready
  );
endinterface

@@ rtl/usdc_out_if.sv @@
interface usdc_out_if import usdc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   intercepted;
  logic [USDC_TIER_W-1:0] match_tier;
  logic [USDC_SLOT_W-1:0] matched_slot;
  logic [USDC_VERD_W-1:0] verdict;

  modport source (
    output valid, intercepted, match_tier, matched_slot, verdict,
    input  ready
  );
  modport sink (
    input  valid, intercepted, match_tier, matched_slot, verdict,
    output ready
  );
endinterface

@@ rtl/udp_socket_demux_classifier_core.sv @@
// UDP socket demultiplexing classifier.
// in_ch carries one command per transfer: classify a packet header, write a
// socket entry or clear one. out_ch returns exactly one result per command,
// in order. Both channels use valid/ready; a transfer happens when both are
// high at a rising clock edge.
// The table is a chain of TABLE_ENTRIES cells, one entry per cell. Each
// command walks the chain one cell per cycle, updating its own cell or
// collecting the lowest hit of each match tier, so later commands see the
// effect of earlier table writes. A result passes through every cell register
// and then the output register, and a new command is taken every cycle unless the chain is frozen.
// The header filters (IPv4 / VLAN, UDP, multicast) sit in front of the first
// cell; the tier choice sits in front of the output register.
// When out_ch is not ready while a result is held, the whole chain freezes
// and in_ch.ready drops; nothing is lost. Reset (rst_n low, synchronous)
// marks every entry invalid at once and empties the chain; there is no
// clearing pass, so commands are taken in the first cycle after reset.
module udp_socket_demux_classifier_core import usdc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = USDC_TABLE_ENTRIES
) (
  input  logic clk,
  input  logic rst_n,
  usdc_in_if.sink    in_ch,
  usdc_out_if.source out_ch
);

  logic        en;
  logic        ipv4;
  logic        chain_v   [TABLE_ENTRIES+1];
  usdc_token_t chain_tok [TABLE_ENTRIES+1];
  usdc_token_t head_tok;
  usdc_token_t tail_tok;

  logic                   out_valid_r;
  logic                   intercepted_r;
  logic                   intercepted_nxt;
  logic [USDC_TIER_W-1:0] tier_r;
  logic [USDC_TIER_W-1:0] tier_nxt;
  logic [USDC_SLOT_W-1:0] slot_r;
  logic [USDC_SLOT_W-1:0] slot_nxt;
  logic [USDC_VERD_W-1:0] verdict_r;
  logic [USDC_VERD_W-1:0] verdict_nxt;

  // chain advances whenever the output register can take a result
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // header filters ahead of the first cell
  assign ipv4 = (in_ch.ether_type == ETYPE_IPV4)
                || (in_ch.ether_type == ETYPE_VLAN && in_ch.vlan_inner_type == ETYPE_IPV4);

  always_comb begin
    head_tok          = '0;
    head_tok.cmd      = in_ch.cmd;
    head_tok.slot     = in_ch.slot;
    head_tok.lcl_addr = in_ch.lcl_addr;
    head_tok.rmt_addr = in_ch.rmt_addr;
    head_tok.lcl_port = in_ch.lcl_port;
    head_tok.rmt_port = in_ch.rmt_port;
    if (in_ch.cmd != CMD_CLASSIFY) begin
      head_tok.verdict = V_TABLE;
    end else if (!ipv4) begin
      head_tok.verdict = V_NOT_IPV4;
    end else if (in_ch.ip_protocol != PROTO_UDP) begin
      head_tok.verdict = V_NOT_UDP;
    end else if (in_ch.lcl_addr[USDC_ADDR_W-1 -: 4] == MCAST_NIB) begin
      head_tok.verdict = V_MULTICAST;
    end else begin
      head_tok.verdict = V_TAKEN;
    end
  end

  assign chain_v[0]   = in_ch.valid;
  assign chain_tok[0] = head_tok;

  // one cell per table entry
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    usdc_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .tok_v_i (chain_v[g]),
      .tok_i   (chain_tok[g]),
      .tok_v_o (chain_v[g+1]),
      .tok_o   (chain_tok[g+1])
    );
  end

  assign tail_tok = chain_tok[TABLE_ENTRIES];

  // pick the winning tier
  always_comb begin
    intercepted_nxt = 1'b0;
    tier_nxt        = TIER_NONE;
    slot_nxt        = '0;
    verdict_nxt     = tail_tok.verdict;
    if (tail_tok.verdict == V_TAKEN) begin
      if (tail_tok.full.hit) begin
        intercepted_nxt = 1'b1;
        tier_nxt        = TIER_FULL;
        slot_nxt        = tail_tok.full.slot;
      end else if (tail_tok.local_only.hit) begin
        intercepted_nxt = 1'b1;
        tier_nxt        = TIER_LOCAL;
        slot_nxt        = tail_tok.local_only.slot;
      end else if (tail_tok.port_only.hit) begin
        intercepted_nxt = 1'b1;
        tier_nxt        = TIER_PORT;
        slot_nxt        = tail_tok.port_only.slot;
      end else begin
        verdict_nxt = V_NO_MATCH;
      end
    end
  end

  // output register, valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain_v[TABLE_ENTRIES];
    end
  end

  // output register, payload
  always_ff @(posedge clk) begin
    if (en) begin
      intercepted_r <= intercepted_nxt;
      tier_r        <= tier_nxt;
      slot_r        <= slot_nxt;
      verdict_r     <= verdict_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.intercepted  = intercepted_r;
  assign out_ch.match_tier   = tier_r;
  assign out_ch.matched_slot = slot_r;
  assign out_ch.verdict      = verdict_r;

  // taken exactly when the verdict says so
  a_taken_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (intercepted_r == (verdict_r == V_TAKEN)))
    else $error("intercepted disagrees with verdict");

  // a result that is not taken names no tier and no slot
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !intercepted_r) |-> (tier_r == TIER_NONE && slot_r == '0))
    else $error("tier or slot set on a miss");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result pending after reset");

endmodule

@@ rtl/usdc_cell.sv @@
module usdc_cell import usdc_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        tok_v_i,
  input  usdc_token_t tok_i,
  output logic        tok_v_o,
  output usdc_token_t tok_o
);

  localparam logic [USDC_SLOT_W-1:0] SLOT_ID   = USDC_SLOT_W'(CELL_IDX);
  localparam bit                     REACHABLE = CELL_IDX < (2 ** USDC_SLOT_W);

  logic                     ent_v_r;
  logic [2*USDC_ADDR_W-1:0] ent_addr_r;
  logic [2*USDC_PORT_W-1:0] ent_port_r;
  logic                     tok_v_r;
  usdc_token_t              tok_r;
  usdc_token_t              tok_nxt;

  logic                     sel;
  logic                     do_write;
  logic                     do_clear;
  logic                     lookup;
  logic                     m_full;
  logic                     m_local;
  logic                     m_port;

  // command addressed to this entry
  assign sel      = REACHABLE && tok_v_i && (tok_i.slot == SLOT_ID);
  assign do_write = sel && (tok_i.cmd == CMD_WRITE);
  assign do_clear = sel && (tok_i.cmd == CMD_CLEAR);

  // three tier compares against the stored entry
  assign lookup  = tok_v_i && (tok_i.cmd == CMD_CLASSIFY) && (tok_i.verdict == V_TAKEN)
                   && ent_v_r;
  assign m_full  = lookup
                   && (ent_addr_r == {tok_i.lcl_addr, tok_i.rmt_addr})
                   && (ent_port_r == {tok_i.lcl_port, tok_i.rmt_port});
  assign m_local = lookup
                   && (ent_addr_r == {tok_i.lcl_addr, ADDR_ANY})
                   && (ent_port_r == {tok_i.lcl_port, {USDC_PORT_W{1'b0}}});
  assign m_port  = lookup
                   && (ent_addr_r == {ADDR_ANY, ADDR_ANY})
                   && (ent_port_r == {tok_i.lcl_port, {USDC_PORT_W{1'b0}}});

  // keep the first (lowest) hit of each tier
  always_comb begin
    tok_nxt = tok_i;
    if (m_full && !tok_i.full.hit) begin
      tok_nxt.full = '{hit: 1'b1, slot: SLOT_ID};
    end
    if (m_local && !tok_i.local_only.hit) begin
      tok_nxt.local_only = '{hit: 1'b1, slot: SLOT_ID};
    end
    if (m_port && !tok_i.port_only.hit) begin
      tok_nxt.port_only = '{hit: 1'b1, slot: SLOT_ID};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
      tok_v_r <= 1'b0;
    end else if (en) begin
      tok_v_r <= tok_v_i;
      if (do_write) begin
        ent_v_r <= 1'b1;
      end else if (do_clear) begin
        ent_v_r <= 1'b0;
      end
    end
  end

  // entry contents and forwarded item
  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
      if (do_write) begin
        ent_addr_r <= {tok_i.lcl_addr, tok_i.rmt_addr};
        ent_port_r <= {tok_i.lcl_port, tok_i.rmt_port};
      end
    end
  end

  assign tok_v_o = tok_v_r;
  assign tok_o   = tok_r;

  // a transfer that clears this entry leaves it invalid
  a_clear_invalidates: assert property (@(posedge clk) disable iff (!rst_n)
    (en && do_clear) |=> !ent_v_r)
    else $error("entry still valid after clear");

  // a write marks the entry valid and stores the port pair of the key
  a_write_stores: assert property (@(posedge clk) disable iff (!rst_n)
    (en && do_write) |=> (ent_v_r
      && ent_port_r == {$past(tok_i.lcl_port), $past(tok_i.rmt_port)}))
    else $error("entry write lost");

  // reset leaves the entry invalid and the stage empty
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!ent_v_r && !tok_v_r))
    else $error("entry or stage busy after reset");

endmodule
